>>> rtl/rmss_pkg.sv
// Package for the row mirror sepia stream block: field widths, register codes,
// the queue entry type and the sepia arithmetic. No dependencies.
`timescale 1ns / 1ps

package rmss_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned PixelW       = 3 * ChanW;
  localparam int unsigned RowWidthW    = 7;
  localparam int unsigned MaxRowPixels = 64;
  localparam int unsigned CfgAddrW     = 4;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned SumW         = 10;

  localparam logic [RowWidthW-1:0] RowWidthRst = 7'd64;

  typedef enum logic [1:0] {
    REG_FLIP  = 2'd0,
    REG_SEPIA = 2'd1,
    REG_WIDTH = 2'd2
  } reg_idx_e;

  // floor(x / 1000) == (x * Recip) >> RecipShift for x below 2^18
  localparam int unsigned Recip      = 268436;
  localparam int unsigned RecipShift = 28;
  localparam int unsigned KW         = 28;
  localparam int unsigned ProdW      = KW + ChanW;

  localparam logic [KW-1:0] KRr = KW'(393 * Recip);
  localparam logic [KW-1:0] KRg = KW'(769 * Recip);
  localparam logic [KW-1:0] KRb = KW'(189 * Recip);
  localparam logic [KW-1:0] KGr = KW'(349 * Recip);
  localparam logic [KW-1:0] KGg = KW'(686 * Recip);
  localparam logic [KW-1:0] KGb = KW'(168 * Recip);
  localparam logic [KW-1:0] KBr = KW'(272 * Recip);
  localparam logic [KW-1:0] KBg = KW'(534 * Recip);
  localparam logic [KW-1:0] KBb = KW'(131 * Recip);

  localparam logic [SumW-1:0] SatMax = 10'd255;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                 is_row;
    logic                 row_end;
    logic [PixelW-1:0]    pixel;
    logic [RowWidthW-1:0] last_pos;
  } cmd_t;

  function automatic logic [ChanW-1:0] sepia_term(input logic [ChanW-1:0] ch,
                                                  input logic [KW-1:0] k);
    logic [ProdW-1:0] p;
    p = ProdW'(ch) * ProdW'(k);
    return p[ProdW-1:RecipShift];
  endfunction

endpackage

>>> rtl/rmss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rmss_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rmss_fifo.sv
// Two-entry command queue between the front and the back part.
// Depends on rmss_pkg for the entry type.
`timescale 1ns / 1ps

module rmss_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmss_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output rmss_pkg::cmd_t head_o,
  output logic          empty_o
);
  import rmss_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;

endmodule

>>> rtl/rmss_front.sv
// Front part: accepts pixels, tracks the column, fills the row store and
// queues pass or row commands. Depends on rmss_pkg.
`timescale 1ns / 1ps

module rmss_front #(
  parameter int unsigned MaxRowPixels = rmss_pkg::MaxRowPixels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rmss_pkg::PixelW-1:0]          pixel_i,
  input  logic                                 flip_i,
  input  logic [rmss_pkg::RowWidthW-1:0]       row_width_i,
  input  logic                                 row_done_i,
  input  logic                                 fifo_full_i,
  output logic                                 push_o,
  output rmss_pkg::cmd_t                       push_cmd_o,
  output logic                                 ram_we_o,
  output logic [$clog2(MaxRowPixels)-1:0]      ram_waddr_o
);
  import rmss_pkg::*;

  localparam int unsigned AW = $clog2(MaxRowPixels);

  logic [AW-1:0]        count_q, count_d;
  logic                 busy_q, busy_d;
  logic                 accept;
  logic                 last;
  logic [RowWidthW-1:0] w_eff;
  logic [RowWidthW-1:0] pos_next;

  always_comb begin
    if (row_width_i == '0) begin
      w_eff = RowWidthW'(1);
    end else if (row_width_i > RowWidthW'(MaxRowPixels)) begin
      w_eff = RowWidthW'(MaxRowPixels);
    end else begin
      w_eff = row_width_i;
    end
  end

  assign in_stall_o = fifo_full_i || busy_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_next   = RowWidthW'(count_q) + RowWidthW'(1);
  assign last       = pos_next >= w_eff;

  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    if (accept) begin
      count_d = last ? '0 : count_q + AW'(1);
    end
    if (row_done_i) begin
      busy_d = 1'b0;
    end
    if (accept && flip_i && last) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
    end
  end

  always_comb begin
    push_cmd_o.is_row   = flip_i;
    push_cmd_o.row_end  = last;
    push_cmd_o.pixel    = pixel_i;
    push_cmd_o.last_pos = RowWidthW'(count_q);
  end

  assign push_o      = accept && (!flip_i || last);
  assign ram_we_o    = accept && flip_i;
  assign ram_waddr_o = count_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !fifo_full_i)
    else $error("push into full queue");

  a_row_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done_i |-> busy_q)
    else $error("row drain finished with no row pending");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ram_we_o)
    else $error("row store written while a row drains");

endmodule

>>> rtl/rmss_back.sv
// Back part: pops commands, reads stored rows in reverse, applies sepia in a
// short pipeline and holds the output register. Depends on rmss_pkg.
`timescale 1ns / 1ps

module rmss_back #(
  parameter int unsigned MaxRowPixels = rmss_pkg::MaxRowPixels
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmss_pkg::cmd_t                    head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              row_done_o,
  input  logic                              sepia_i,
  output logic                              ram_re_o,
  output logic [$clog2(MaxRowPixels)-1:0]   ram_raddr_o,
  input  logic [rmss_pkg::PixelW-1:0]       ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmss_pkg::ChanW-1:0]        out_red_o,
  output logic [rmss_pkg::ChanW-1:0]        out_green_o,
  output logic [rmss_pkg::ChanW-1:0]        out_blue_o,
  output logic                              row_end_o
);
  import rmss_pkg::*;

  localparam int unsigned AW = $clog2(MaxRowPixels);

  back_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          advance;
  logic          issue_valid, issue_end;

  logic              v1_q, ram1_q, end1_q;
  logic [PixelW-1:0] pix1_q;
  logic              v2_q, end2_q;
  logic [PixelW-1:0] pix2_q;
  logic [ChanW-1:0]  t_q [9];
  logic [ChanW-1:0]  t_d [9];
  logic              v3_q, end3_q;
  logic [PixelW-1:0] pix3_q, pix3_d;

  logic [PixelW-1:0] px;
  logic [SumW-1:0]   sum_r, sum_g, sum_b;

  assign advance = !v3_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (advance && !empty_i && head_i.is_row) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (advance && idx_q == '0) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    issue_valid = 1'b0;
    issue_end   = 1'b0;
    row_done_o  = 1'b0;
    ram_re_o    = advance;
    idx_d       = idx_q;
    case (state_q)
      BK_IDLE: begin
        pop_o       = advance && !empty_i;
        issue_valid = pop_o && !head_i.is_row;
        issue_end   = head_i.row_end;
        if (pop_o && head_i.is_row) begin
          idx_d = head_i.last_pos[AW-1:0];
        end
      end
      BK_DRAIN: begin
        issue_valid = advance;
        issue_end   = idx_q == '0;
        row_done_o  = advance && idx_q == '0;
        if (advance) begin
          idx_d = idx_q - AW'(1);
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  assign ram_raddr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (advance) begin
        v1_q <= issue_valid;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  assign px = ram1_q ? ram_rdata_i : pix1_q;

  always_comb begin
    t_d[0] = sepia_term(px[23:16], KRr);
    t_d[1] = sepia_term(px[15:8],  KRg);
    t_d[2] = sepia_term(px[7:0],   KRb);
    t_d[3] = sepia_term(px[23:16], KGr);
    t_d[4] = sepia_term(px[15:8],  KGg);
    t_d[5] = sepia_term(px[7:0],   KGb);
    t_d[6] = sepia_term(px[23:16], KBr);
    t_d[7] = sepia_term(px[15:8],  KBg);
    t_d[8] = sepia_term(px[7:0],   KBb);
  end

  always_comb begin
    sum_r = SumW'(t_q[0]) + SumW'(t_q[1]) + SumW'(t_q[2]);
    sum_g = SumW'(t_q[3]) + SumW'(t_q[4]) + SumW'(t_q[5]);
    sum_b = SumW'(t_q[6]) + SumW'(t_q[7]) + SumW'(t_q[8]);
    if (sepia_i) begin
      pix3_d[23:16] = (sum_r > SatMax) ? ChanW'(SatMax) : sum_r[ChanW-1:0];
      pix3_d[15:8]  = (sum_g > SatMax) ? ChanW'(SatMax) : sum_g[ChanW-1:0];
      pix3_d[7:0]   = (sum_b > SatMax) ? ChanW'(SatMax) : sum_b[ChanW-1:0];
    end else begin
      pix3_d = pix2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ram1_q <= state_q == BK_DRAIN;
      end1_q <= issue_end;
      pix1_q <= head_i.pixel;
      end2_q <= end1_q;
      pix2_q <= px;
      t_q    <= t_d;
      end3_q <= end2_q;
      pix3_q <= pix3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_red_o   = pix3_q[23:16];
  assign out_green_o = pix3_q[15:8];
  assign out_blue_o  = pix3_q[7:0];
  assign row_end_o   = end3_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_drain_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_done_o |=> (v1_q && end1_q && ram1_q))
    else $error("row drain did not close with a marked read");

  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && v2_q) |=> v3_q)
    else $error("pixel lost between pipeline stages");

endmodule

>>> rtl/row_mirror_sepia_stream_top.sv
// Top level of the row mirror sepia stream block: APB registers and the
// front, queue, row store and back instances. Depends on rmss_pkg and all rmss_* modules.
`timescale 1ns / 1ps

// With flip off, one pixel per cycle goes in unless stalled, and its transfer is offered
// once it has passed the queue and the sepia pipeline. With flip on, a row of n pixels
// is taken at one per cycle, unless stalled, into the row store. On its last pixel the
// input stalls while the back part reads the row out of the store's single read port,
// last pixel first, one per cycle unless the output stalls. Sepia is a three-stage
// pipeline (row store read, nine constant multiplies with divide by 1000, sum and clamp).
// The user must change configuration only while the block is idle; it is not enforced.
module row_mirror_sepia_stream_top #(
  parameter int unsigned MaxRowPixels = rmss_pkg::MaxRowPixels
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rmss_pkg::ChanW-1:0]      in_red_i,
  input  logic [rmss_pkg::ChanW-1:0]      in_green_i,
  input  logic [rmss_pkg::ChanW-1:0]      in_blue_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rmss_pkg::ChanW-1:0]      out_red_o,
  output logic [rmss_pkg::ChanW-1:0]      out_green_o,
  output logic [rmss_pkg::ChanW-1:0]      out_blue_o,
  output logic                            row_end_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmss_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rmss_pkg::CfgDataW-1:0]   pwdata,
  output logic [rmss_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import rmss_pkg::*;

  localparam int unsigned AW = $clog2(MaxRowPixels);

  logic                 flip_q, flip_d;
  logic                 sepia_q, sepia_d;
  logic [RowWidthW-1:0] width_q, width_d;
  logic                 wr_en;
  reg_idx_e             reg_idx;

  logic          push, pop, full, empty, row_done;
  cmd_t          push_cmd, head;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PixelW-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    flip_d  = flip_q;
    sepia_d = sepia_q;
    width_d = width_q;
    prdata  = '0;
    case (reg_idx)
      REG_FLIP: begin
        prdata = CfgDataW'(flip_q);
        if (wr_en) begin
          flip_d = pwdata[0];
        end
      end
      REG_SEPIA: begin
        prdata = CfgDataW'(sepia_q);
        if (wr_en) begin
          sepia_d = pwdata[0];
        end
      end
      REG_WIDTH: begin
        prdata = CfgDataW'(width_q);
        if (wr_en) begin
          width_d = pwdata[RowWidthW-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q  <= 1'b0;
      sepia_q <= 1'b0;
      width_q <= RowWidthRst;
    end else begin
      flip_q  <= flip_d;
      sepia_q <= sepia_d;
      width_q <= width_d;
    end
  end

  rmss_front #(
    .MaxRowPixels(MaxRowPixels)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     ({in_red_i, in_green_i, in_blue_i}),
    .flip_i      (flip_q),
    .row_width_i (width_q),
    .row_done_i  (row_done),
    .fifo_full_i (full),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr)
  );

  rmss_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  rmss_ram #(
    .Width(PixelW),
    .Depth(MaxRowPixels)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_cmd.pixel),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rmss_back #(
    .MaxRowPixels(MaxRowPixels)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .row_done_o  (row_done),
    .sepia_i     (sepia_q),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o)
  );

endmodule

>>> tb/sv/row_mirror_sepia_stream_top_tb.sv
// Testbench for row_mirror_sepia_stream_top: drives pixels and APB settings and
// predicts the mirrored, sepia-toned stream. Checks every transfer in order.
// Depends on rmss_pkg and the row_mirror_sepia_stream_top RTL.
`timescale 1ns / 1ps

module row_mirror_sepia_stream_top_tb;
  import rmss_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned RandomItems  = 150;
  localparam logic [CfgAddrW-1:0] UnusedAddr = 4'hC;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             row_end;
  } toned_pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ChanW-1:0]    in_red_i;
  logic [ChanW-1:0]    in_green_i;
  logic [ChanW-1:0]    in_blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ChanW-1:0]    out_red_o;
  logic [ChanW-1:0]    out_green_o;
  logic [ChanW-1:0]    out_blue_o;
  logic                row_end_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Predictor state
  logic                 flip_on;
  logic                 tone_on;
  logic [RowWidthW-1:0] width_reg;
  int unsigned          column_pos;
  logic [PixelW-1:0]    row_copy [MaxRowPixels];
  bit                   row_written [MaxRowPixels];
  toned_pixel_t         pending_pixels [$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned reg_writes;
  bit          send_idle_on;
  bit          stall_on;
  int unsigned stall_left;

  row_mirror_sepia_stream_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles, %0d transfers still expected",
             cycle_count, pending_pixels.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic toned_pixel_t tone_pixel(input logic [PixelW-1:0] pix,
                                              input logic last);
    int unsigned r, g, b, nr, ng, nb;
    toned_pixel_t res;
    r = pix[23:16];
    g = pix[15:8];
    b = pix[7:0];
    if (tone_on) begin
      nr = r * 393 / 1000 + g * 769 / 1000 + b * 189 / 1000;
      ng = r * 349 / 1000 + g * 686 / 1000 + b * 168 / 1000;
      nb = r * 272 / 1000 + g * 534 / 1000 + b * 131 / 1000;
      r = (nr > 255) ? 255 : nr;
      g = (ng > 255) ? 255 : ng;
      b = (nb > 255) ? 255 : nb;
    end
    res.red     = r[7:0];
    res.green   = g[7:0];
    res.blue    = b[7:0];
    res.row_end = last;
    return res;
  endfunction

  task automatic predict_row_output(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                    input logic [ChanW-1:0] b);
    int unsigned w;
    int unsigned pos;
    logic        last;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MaxRowPixels) w = MaxRowPixels;
    pos = column_pos;
    if (pos > MaxRowPixels - 1) pos = MaxRowPixels - 1;
    last = (pos + 1 >= w);
    column_pos = last ? 0 : pos + 1;
    if (!flip_on) begin
      pending_pixels.push_back(tone_pixel({r, g, b}, last));
    end else begin
      row_copy[pos]    = {r, g, b};
      row_written[pos] = 1'b1;
      if (last) begin
        for (int k = 0; k <= pos; k++) begin
          pending_pixels.push_back(tone_pixel(row_copy[pos - k], k == pos));
        end
      end
    end
  endtask

  // Check each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    toned_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected output transfer", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
        if (out_green_o !== want.green)
          report_mismatch("out_green", out_green_o, want.green);
        if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
        if (row_end_o !== want.row_end)
          report_mismatch("row_end", row_end_o, want.row_end);
      end
    end
  end

  // Output stall bursts
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = $urandom_range(1, 10) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_red_i   = r;
    in_green_i = g;
    in_blue_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    predict_row_output(r, g, b);
    pixels_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random_pixel();
    send_pixel(ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
               ChanW'($urandom_range(0, 255)));
  endtask

  task automatic apb_read_check(input logic [CfgAddrW-1:0] addr,
                                input logic [CfgDataW-1:0] want);
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
    case (addr[3:2])
      REG_FLIP: begin
        flip_on = data[0];
        apb_read_check(addr, {31'd0, data[0]});
      end
      REG_SEPIA: begin
        tone_on = data[0];
        apb_read_check(addr, {31'd0, data[0]});
      end
      REG_WIDTH: begin
        width_reg = data[RowWidthW-1:0];
        apb_read_check(addr, {25'd0, data[RowWidthW-1:0]});
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input bit flip, input bit sepia, input int unsigned width);
    wait_idle();
    apb_write({REG_FLIP, 2'b00}, {31'd0, flip});
    apb_write({REG_SEPIA, 2'b00}, {31'd0, sepia});
    apb_write({REG_WIDTH, 2'b00}, width);
  endtask

  task automatic test_reset_passthrough();
    apb_read_check({REG_FLIP, 2'b00}, 0);
    apb_read_check({REG_SEPIA, 2'b00}, 0);
    apb_read_check({REG_WIDTH, 2'b00}, CfgDataW'(RowWidthRst));
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    // shrink width to no more than the current column: next pixel closes the row
    wait_idle();
    apb_write({REG_WIDTH, 2'b00}, 2);
    send_pixel(8'h12, 8'h34, 8'h56);
  endtask

  task automatic test_sepia_extremes();
    set_config(0, 1, 3);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h80, 8'h40, 8'h20);
  endtask

  task automatic test_width_bounds();
    set_config(1, 0, 1);
    send_pixel(8'hA5, 8'h5A, 8'h3C);
    send_pixel(8'h01, 8'h02, 8'h03);
    set_config(1, 0, 0);
    send_pixel(8'hC3, 8'h96, 8'h69);
    wait_idle();
    apb_write(UnusedAddr, 32'hFFFF_FFFF);
    send_pixel(8'h7F, 8'h80, 8'hFE);
  endtask

  task automatic test_flip_clear_midrow();
    set_config(1, 1, 5);
    repeat (3) send_random_pixel();
    wait_idle();
    apb_write({REG_FLIP, 2'b00}, 0);
    repeat (2) send_random_pixel();
  endtask

  task automatic test_flip_set_midrow();
    set_config(1, 0, 4);
    repeat (4) send_random_pixel();
    wait_idle();
    apb_write({REG_FLIP, 2'b00}, 0);
    repeat (2) send_random_pixel();
    wait_idle();
    apb_write({REG_FLIP, 2'b00}, 1);
    repeat (2) send_random_pixel();
  endtask

  task automatic test_width_shrink_midrow();
    set_config(1, 1, 8);
    repeat (4) send_random_pixel();
    wait_idle();
    apb_write({REG_WIDTH, 2'b00}, 2);
    send_random_pixel();
  endtask

  function automatic int unsigned pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) return $urandom_range(1, 8);
    if (sel < 15) return $urandom_range(9, 20);
    if (sel == 15) return 1;
    if (sel == 16) return 0;
    if (sel == 17) return 64;
    if (sel == 18) return $urandom_range(65, 127);
    return $urandom_range(21, 63);
  endfunction

  function automatic bit midrow_flip_safe();
    for (int i = 0; i < column_pos; i++) begin
      if (!row_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic test_random_mix();
    int unsigned start;
    int unsigned width;
    int unsigned eff;
    int unsigned count;
    bit          flip;
    bit          first;
    start = pixels_sent;
    first = 1'b1;
    while (pixels_sent - start < RandomItems) begin
      flip  = first ? 1'b1 : $urandom_range(0, 2) != 0;
      width = first ? 127 : pick_width();
      first = 1'b0;
      wait_idle();
      if (flip && column_pos > 0 && !midrow_flip_safe()) flip = 1'b0;
      set_config(flip, $urandom_range(0, 1) != 0, width);
      send_idle_on = $urandom_range(0, 3) != 0;
      stall_on     = $urandom_range(0, 3) != 0;
      eff = (width == 0) ? 1 : (width > MaxRowPixels ? MaxRowPixels : width);
      if (flip) begin
        count = (eff >= 21) ? eff : eff * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(0, eff - 1);
      end else begin
        count = $urandom_range(5, 25);
      end
      repeat (count) send_random_pixel();
    end
  endtask

  task automatic test_no_idle_tail();
    set_config(1, 1, 6);
    send_idle_on = 1'b0;
    stall_on     = 1'b0;
    repeat (24) send_random_pixel();
    set_config(0, 1, 64);
    repeat (8) send_random_pixel();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_red_i     = '0;
    in_green_i   = '0;
    in_blue_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    flip_on      = 1'b0;
    tone_on      = 1'b0;
    width_reg    = RowWidthRst;
    column_pos   = 0;
    error_count  = 0;
    cycle_count  = 0;
    pixels_sent  = 0;
    pixels_checked = 0;
    reg_writes   = 0;
    send_idle_on = 1'b1;
    stall_on     = 1'b1;
    for (int i = 0; i < MaxRowPixels; i++) begin
      row_copy[i]    = '0;
      row_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_passthrough();
    test_sepia_extremes();
    test_width_bounds();
    test_flip_clear_midrow();
    test_flip_set_midrow();
    test_width_shrink_midrow();
    test_random_mix();
    test_no_idle_tail();

    wait_idle();
    $display("Sent %0d pixels, checked %0d output transfers, %0d register writes",
             pixels_sent, pixels_checked, reg_writes);
    $display("Covered passthrough, row mirroring, sepia clamping, width bounds and mid-row changes");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
